/* sv/pdip_pkg.sv */
// Shared types, constants and helpers of the presence detector.
package pdip_pkg;

    localparam int SLOT_W    = 6;
    localparam int DATA_W    = 32;
    localparam int ACC_W     = 36;
    localparam int MUL_A_W   = 19;
    localparam int MUL_B_W   = 34;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int FRAC_W    = 16;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;

    localparam logic [DATA_W-1:0] START_DIST = 32'h0064_0000;

    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_REARM  = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [2:0] REG_INVERSE_GAIN  = 3'd0;
    localparam logic [2:0] REG_FEEDBACK_ONE  = 3'd1;
    localparam logic [2:0] REG_FEEDBACK_TWO  = 3'd2;
    localparam logic [2:0] REG_PEAK_LEAK     = 3'd3;
    localparam logic [2:0] REG_RISE_FRACTION = 3'd4;
    localparam logic [2:0] REG_MARGIN        = 3'd5;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [7:0]        reading;
        logic [SLOT_W-1:0] read_slot;
    } t_in_item;

    typedef struct packed {
        logic signed [DATA_W-1:0] filtered_distance;
        logic signed [DATA_W-1:0] peak_distance;
        logic                     present;
        logic                     recording;
        logic [SLOT_W-1:0]        write_position;
        logic signed [DATA_W-1:0] entry_distance;
        logic signed [DATA_W-1:0] entry_peak;
    } t_out_item;

    typedef struct packed {
        logic [17:0]        inverse_gain;
        logic signed [17:0] feedback_one;
        logic signed [17:0] feedback_two;
        logic [15:0]        peak_leak;
        logic [16:0]        peak_rise_fraction;
        logic [23:0]        presence_margin;
    } t_cfg;

    typedef enum logic [3:0] {
        STEP_NONE   = 4'd0,
        STEP_GAIN   = 4'd1,
        STEP_FB1    = 4'd2,
        STEP_FB2    = 4'd3,
        STEP_SUM    = 4'd4,
        STEP_LEAK   = 4'd5,
        STEP_DIFF   = 4'd6,
        STEP_RISE   = 4'd7,
        STEP_PEAK   = 4'd8,
        STEP_COMMIT = 4'd9,
        STEP_READ   = 4'd10,
        STEP_REARM  = 4'd11
    } t_step;

    typedef struct packed {
        logic  take;
        t_step step;
        logic  load_out;
    } t_cmd;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic fits;
        logic signed [DATA_W-1:0] y;
        fits = (&x[ACC_W-1:DATA_W-1]) || !(|x[ACC_W-1:DATA_W-1]);
        if (fits) begin
            y = x[DATA_W-1:0];
        end else if (x[ACC_W-1]) begin
            y = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            y = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return y;
    endfunction

endpackage

/* sv/pdip_cfg.sv */
// Configuration register file with its APB-style access port.
module pdip_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pdip_pkg::PADDR_W-1:0] paddr,
    input  logic [pdip_pkg::PDATA_W-1:0] pwdata,
    output logic [pdip_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    output pdip_pkg::t_cfg               o_cfg
);
    import pdip_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_index;
    logic       w_write;

    assign w_index = paddr[PADDR_W-1:2];
    assign w_write = psel && penable && pwrite;
    assign pready  = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.inverse_gain       <= 18'd65536;
            r_cfg.feedback_one       <= '0;
            r_cfg.feedback_two       <= '0;
            r_cfg.peak_leak          <= 16'd109;
            r_cfg.peak_rise_fraction <= 17'd6554;
            r_cfg.presence_margin    <= '0;
        end else if (w_write) begin
            case (w_index)
                REG_INVERSE_GAIN:  r_cfg.inverse_gain       <= pwdata[17:0];
                REG_FEEDBACK_ONE:  r_cfg.feedback_one       <= pwdata[17:0];
                REG_FEEDBACK_TWO:  r_cfg.feedback_two       <= pwdata[17:0];
                REG_PEAK_LEAK:     r_cfg.peak_leak          <= pwdata[15:0];
                REG_RISE_FRACTION: r_cfg.peak_rise_fraction <= pwdata[16:0];
                REG_MARGIN:        r_cfg.presence_margin    <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_index)
            REG_INVERSE_GAIN:  prdata = {14'd0, r_cfg.inverse_gain};
            REG_FEEDBACK_ONE:  prdata = {{14{r_cfg.feedback_one[17]}}, r_cfg.feedback_one};
            REG_FEEDBACK_TWO:  prdata = {{14{r_cfg.feedback_two[17]}}, r_cfg.feedback_two};
            REG_PEAK_LEAK:     prdata = {16'd0, r_cfg.peak_leak};
            REG_RISE_FRACTION: prdata = {15'd0, r_cfg.peak_rise_fraction};
            REG_MARGIN:        prdata = {8'd0, r_cfg.presence_margin};
            default:           prdata = '0;
        endcase
    end

endmodule

/* sv/pdip_ctrl.sv */
// Sequencer that steps the datapath through one item and owns the handshakes.
module pdip_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [1:0]     i_opcode,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output pdip_pkg::t_cmd o_cmd
);
    import pdip_pkg::*;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_GAIN   = 12'b0000_0000_0010,
        S_FB1    = 12'b0000_0000_0100,
        S_FB2    = 12'b0000_0000_1000,
        S_SUM    = 12'b0000_0001_0000,
        S_LEAK   = 12'b0000_0010_0000,
        S_DIFF   = 12'b0000_0100_0000,
        S_RISE   = 12'b0000_1000_0000,
        S_PEAK   = 12'b0001_0000_0000,
        S_COMMIT = 12'b0010_0000_0000,
        S_READ   = 12'b0100_0000_0000,
        S_EMIT   = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd.take     = 1'b0;
        o_cmd.step     = STEP_NONE;
        o_cmd.load_out = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    case (i_opcode)
                        OP_SAMPLE: n_state = S_GAIN;
                        OP_READ:   n_state = S_READ;
                        OP_REARM: begin
                            o_cmd.step = STEP_REARM;
                            n_state    = S_EMIT;
                        end
                        default:   n_state = S_EMIT;
                    endcase
                end
            end
            S_GAIN: begin
                o_cmd.step = STEP_GAIN;
                n_state    = S_FB1;
            end
            S_FB1: begin
                o_cmd.step = STEP_FB1;
                n_state    = S_FB2;
            end
            S_FB2: begin
                o_cmd.step = STEP_FB2;
                n_state    = S_SUM;
            end
            S_SUM: begin
                o_cmd.step = STEP_SUM;
                n_state    = S_LEAK;
            end
            S_LEAK: begin
                o_cmd.step = STEP_LEAK;
                n_state    = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.step = STEP_DIFF;
                n_state    = S_RISE;
            end
            S_RISE: begin
                o_cmd.step = STEP_RISE;
                n_state    = S_PEAK;
            end
            S_PEAK: begin
                o_cmd.step = STEP_PEAK;
                n_state    = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.step = STEP_COMMIT;
                n_state    = S_EMIT;
            end
            S_READ: begin
                o_cmd.step = STEP_READ;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* sv/pdip_dp.sv */
// Datapath: shared multiplier, filter and peak state, log store and result register.
module pdip_dp #(
    parameter int LOG_DEPTH = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pdip_pkg::t_cmd      i_cmd,
    input  pdip_pkg::t_cfg      i_cfg,
    input  pdip_pkg::t_in_item  i_item,
    output pdip_pkg::t_out_item o_item
);
    import pdip_pkg::*;

    localparam int ADDR_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int FILL_W = $clog2(LOG_DEPTH + 1);
    localparam int IDX_W  = (ADDR_W > SLOT_W) ? ADDR_W : SLOT_W;
    localparam int CMP_W  = (IDX_W > FILL_W) ? IDX_W : FILL_W;

    // filter and peak state
    logic signed [DATA_W-1:0] r_now;
    logic signed [DATA_W-1:0] r_prev;
    logic signed [DATA_W-1:0] r_prev2;
    logic signed [DATA_W-1:0] r_peak;
    logic                     r_present;
    logic                     r_record;
    logic [ADDR_W-1:0]        r_ptr;
    logic [FILL_W-1:0]        r_fill;

    // per-item working registers
    logic [7:0]               r_reading;
    logic [SLOT_W-1:0]        r_slot;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [DATA_W-1:0] r_cand_now;
    logic signed [DATA_W-1:0] r_cand_peak;
    logic signed [MUL_B_W-1:0] r_diff;
    logic                     r_gt;
    logic                     r_rd_hit;
    logic [2*DATA_W-1:0]      r_rd_data;
    t_out_item                r_out;

    logic [2*DATA_W-1:0]      mem [LOG_DEPTH];

    logic signed [MUL_A_W-1:0] w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PROD_W-1:0]  w_mul_p;
    logic signed [ACC_W-1:0]   w_floor;
    logic signed [ACC_W-1:0]   w_leak;
    logic signed [ACC_W-1:0]   w_peak_up;
    logic signed [ACC_W-1:0]   w_now_ext;
    logic signed [ACC_W-1:0]   w_limit;
    logic signed [MUL_B_W-1:0] w_diff;
    logic                      w_present;
    logic                      w_rec_new;
    logic                      w_commit;
    logic                      w_mem_we;
    logic [IDX_W-1:0]          w_slot_ext;
    logic [IDX_W-1:0]          w_ptr_ext;
    logic                      w_hit;
    t_out_item                 n_out;

    always_comb begin
        case (i_cmd.step)
            STEP_GAIN: begin
                w_mul_a = {1'b0, i_cfg.inverse_gain};
                w_mul_b = {{(MUL_B_W-8){1'b0}}, r_reading};
            end
            STEP_FB1: begin
                w_mul_a = {i_cfg.feedback_one[17], i_cfg.feedback_one};
                w_mul_b = {{(MUL_B_W-DATA_W){r_now[DATA_W-1]}}, r_now};
            end
            STEP_FB2: begin
                w_mul_a = {i_cfg.feedback_two[17], i_cfg.feedback_two};
                w_mul_b = {{(MUL_B_W-DATA_W){r_prev[DATA_W-1]}}, r_prev};
            end
            STEP_RISE: begin
                w_mul_a = {2'b00, i_cfg.peak_rise_fraction};
                w_mul_b = r_diff;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p   = w_mul_a * w_mul_b;
    assign w_floor   = $signed(r_prod[FRAC_W +: ACC_W]);
    assign w_leak    = {{(ACC_W-DATA_W){r_peak[DATA_W-1]}}, r_peak}
                     - {{(ACC_W-16){1'b0}}, i_cfg.peak_leak};
    assign w_peak_up = {{(ACC_W-DATA_W){r_cand_peak[DATA_W-1]}}, r_cand_peak} + w_floor;
    assign w_diff    = {{(MUL_B_W-DATA_W){r_cand_now[DATA_W-1]}}, r_cand_now}
                     - {{(MUL_B_W-DATA_W){r_cand_peak[DATA_W-1]}}, r_cand_peak};
    assign w_now_ext = {{(ACC_W-DATA_W){r_cand_now[DATA_W-1]}}, r_cand_now};
    assign w_limit   = {{(ACC_W-DATA_W){r_cand_peak[DATA_W-1]}}, r_cand_peak}
                     - {{(ACC_W-24){1'b0}}, i_cfg.presence_margin};
    assign w_present = (w_now_ext < w_limit);
    assign w_rec_new = r_record && !w_present;
    assign w_commit  = (i_cmd.step == STEP_COMMIT);
    assign w_mem_we  = w_commit && w_rec_new;

    assign w_slot_ext = IDX_W'(r_slot);
    assign w_ptr_ext  = IDX_W'(r_ptr);
    assign w_hit      = (CMP_W'(w_slot_ext) < CMP_W'(r_fill));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now     <= '0;
            r_prev    <= START_DIST;
            r_prev2   <= START_DIST;
            r_peak    <= '0;
            r_present <= 1'b0;
            r_record  <= 1'b1;
            r_ptr     <= '0;
            r_fill    <= '0;
        end else if (w_commit) begin
            r_now     <= r_cand_now;
            r_prev    <= r_now;
            r_prev2   <= r_prev;
            r_peak    <= r_cand_peak;
            r_present <= w_present;
            r_record  <= w_rec_new;
            if (w_rec_new) begin
                r_ptr <= (r_ptr == ADDR_W'(LOG_DEPTH - 1)) ? '0 : r_ptr + 1'b1;
                if (r_fill != FILL_W'(LOG_DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end else if (i_cmd.step == STEP_REARM) begin
            r_record <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_reading <= i_item.reading;
            r_slot    <= i_item.read_slot;
            r_rd_hit  <= 1'b0;
        end
        case (i_cmd.step)
            STEP_GAIN: begin
                r_prod <= w_mul_p;
            end
            STEP_FB1: begin
                r_acc  <= r_prod[ACC_W-1:0];
                r_prod <= w_mul_p;
            end
            STEP_FB2: begin
                r_acc  <= r_acc - w_floor;
                r_prod <= w_mul_p;
            end
            STEP_SUM: begin
                r_acc <= r_acc - w_floor;
            end
            STEP_LEAK: begin
                r_cand_now  <= sat32(r_acc);
                r_cand_peak <= sat32(w_leak);
            end
            STEP_DIFF: begin
                r_diff <= w_diff;
                r_gt   <= (r_cand_now > r_cand_peak);
            end
            STEP_RISE: begin
                r_prod <= w_mul_p;
            end
            STEP_PEAK: begin
                if (r_gt) begin
                    r_cand_peak <= sat32(w_peak_up);
                end
            end
            STEP_READ: begin
                r_rd_hit <= w_hit;
            end
            default: ;
        endcase
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[r_ptr] <= {r_cand_now, r_cand_peak};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step == STEP_READ) begin
            r_rd_data <= mem[w_slot_ext[ADDR_W-1:0]];
        end
    end

    always_comb begin
        n_out.filtered_distance = r_now;
        n_out.peak_distance     = r_peak;
        n_out.present           = r_present;
        n_out.recording         = r_record;
        n_out.write_position    = w_ptr_ext[SLOT_W-1:0];
        n_out.entry_distance    = r_rd_hit ? r_rd_data[2*DATA_W-1:DATA_W] : '0;
        n_out.entry_peak        = r_rd_hit ? r_rd_data[DATA_W-1:0] : '0;
    end

    assign o_item = r_out;

endmodule

/* sv/presence_detector_iir_peak.sv */
// Top level of the presence detector: second-order filter, leaky peak track and log store.
//
// Input channel (i_in_valid / o_in_ready / i_in_item) takes one item at a time:
// opcode 0 feeds a range reading, 1 re-arms recording, 2 reads a log entry.
// Output channel (o_out_valid / i_out_ready / o_out_item) returns one item per
// input item, reporting the state after that item.
// A sample runs through one shared 19x34 multiplier in a fixed sequence of
// steps (gain, first and second feedback, sum, leak, difference, rise, peak,
// commit); the result is then registered and only after that is the next item
// taken. A read item makes one registered read of the log memory.
// The result sits in an output register; if the receiver stalls, the block
// finishes the next item and then holds it until the register drains.
// Reset clears the filter to its start values, the peak to zero, enables
// recording and empties the log: entries never written read as zero, tracked
// by a fill count, so no clearing pass is needed. The user must write registers
// through the APB-style port only while the block is idle, which is not enforced.
module presence_detector_iir_peak #(
    parameter int LOG_DEPTH = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  pdip_pkg::t_in_item           i_in_item,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output pdip_pkg::t_out_item          o_out_item,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pdip_pkg::PADDR_W-1:0] paddr,
    input  logic [pdip_pkg::PDATA_W-1:0] pwdata,
    output logic [pdip_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import pdip_pkg::*;

    t_cfg w_cfg;
    t_cmd w_cmd;

    pdip_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    pdip_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_in_item.opcode),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    pdip_dp #(
        .LOG_DEPTH (LOG_DEPTH)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_cfg   (w_cfg),
        .i_item  (i_in_item),
        .o_item  (o_out_item)
    );

`ifndef SYNTHESIS
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input accepted again while an item is in work");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("result register overwritten before it drained");

    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.load_out))
        else $error("output valid raised without a result load");

    a_take_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.take |-> (i_in_valid && o_in_ready))
        else $error("item latched without a handshake");
`endif

endmodule

/* tb/tb_presence_detector_iir_peak.sv */
// Testbench for the presence detector: directed table, then random traces against a predictor.
`timescale 1ns / 1ps

module tb_presence_detector_iir_peak;
    import pdip_pkg::*;

    localparam int LOG_DEPTH = 64;
    localparam int N_PHASES = 10;
    localparam int PHASE_ITEMS = 92;
    localparam int STALL_LIMIT = 4000;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct {
        bit          is_cfg;
        logic [2:0]  reg_idx;
        logic [31:0] value;
        t_in_item    item;
        bit          typed;
        t_out_item   want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in_item i_in_item;
    logic o_out_valid;
    logic i_out_ready;
    t_out_item o_out_item;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    logic [17:0]        gain_r = 18'd65536;
    logic signed [17:0] fb1_r = '0;
    logic signed [17:0] fb2_r = '0;
    logic [15:0]        leak_r = 16'd109;
    logic [16:0]        rise_r = 17'd6554;
    logic [23:0]        margin_r = '0;

    logic signed [31:0] flt0 = '0;
    logic signed [31:0] flt1 = START_DIST;
    logic signed [31:0] flt2 = START_DIST;
    logic signed [31:0] peak_q = '0;
    logic               pres_q = 1'b0;
    logic               rec_q = 1'b1;
    logic [SLOT_W-1:0]  wr_ptr = '0;
    logic signed [31:0] log_flt [LOG_DEPTH];
    logic signed [31:0] log_pk [LOG_DEPTH];

    t_out_item expected_reports[$];
    t_stim_row directed[$];

    bit calm = 1'b0;
    int err_count = 0;
    int n_sample = 0;
    int n_read = 0;
    int n_rearm = 0;
    int n_unused = 0;
    int n_writes = 0;
    int reports_checked = 0;
    int presence_hits = 0;
    int stall_cycles;

    presence_detector_iir_peak #(
        .LOG_DEPTH(LOG_DEPTH)
    ) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_item(i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item(o_out_item),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic logic signed [31:0] clamp32(input longint x);
        if (x > 64'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (x < -64'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return x[31:0];
    endfunction

    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic t_in_item mk_item(input logic [1:0] op, input logic [7:0] rd,
                                         input logic [SLOT_W-1:0] sl);
        t_in_item it;
        it.opcode = op;
        it.reading = rd;
        it.read_slot = sl;
        return it;
    endfunction

    function automatic t_stim_row item_row(input logic [1:0] op, input logic [7:0] rd,
                                           input logic [SLOT_W-1:0] sl);
        t_stim_row r;
        r.is_cfg = 1'b0;
        r.reg_idx = '0;
        r.value = '0;
        r.item = mk_item(op, rd, sl);
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic t_stim_row cfg_row(input logic [2:0] idx, input logic [31:0] value);
        t_stim_row r;
        r = item_row(OP_SAMPLE, '0, '0);
        r.is_cfg = 1'b1;
        r.reg_idx = idx;
        r.value = value;
        return r;
    endfunction

    function automatic t_stim_row typed_row(input logic [1:0] op, input logic [7:0] rd,
                                            input logic [SLOT_W-1:0] sl,
                                            input logic signed [31:0] f,
                                            input logic signed [31:0] p,
                                            input logic pres, input logic rec,
                                            input logic [SLOT_W-1:0] wp,
                                            input logic signed [31:0] ed,
                                            input logic signed [31:0] ep);
        t_stim_row r;
        r = item_row(op, rd, sl);
        r.typed = 1'b1;
        r.want.filtered_distance = f;
        r.want.peak_distance = p;
        r.want.present = pres;
        r.want.recording = rec;
        r.want.write_position = wp;
        r.want.entry_distance = ed;
        r.want.entry_peak = ep;
        return r;
    endfunction

    task automatic detector_step(input t_in_item it, output t_out_item r);
        longint term_in;
        longint term_a;
        longint term_b;
        longint excess;
        longint lift;
        r = '0;
        case (it.opcode)
            OP_SAMPLE: begin
                flt2 = flt1;
                flt1 = flt0;
                term_in = longint'(it.reading) * longint'(gain_r);
                term_a = (longint'(fb1_r) * longint'(flt1)) >>> FRAC_W;
                term_b = (longint'(fb2_r) * longint'(flt2)) >>> FRAC_W;
                flt0 = clamp32(term_in - term_a - term_b);
                peak_q = clamp32(longint'(peak_q) - longint'(leak_r));
                if (flt0 > peak_q) begin
                    excess = longint'(flt0) - longint'(peak_q);
                    lift = (longint'(rise_r) * excess) >>> FRAC_W;
                    peak_q = clamp32(longint'(peak_q) + lift);
                end
                pres_q = longint'(flt0) < (longint'(peak_q) - longint'(margin_r));
                rec_q = rec_q && !pres_q;
                if (rec_q) begin
                    log_flt[wr_ptr] = flt0;
                    log_pk[wr_ptr] = peak_q;
                    wr_ptr = (int'(wr_ptr) == LOG_DEPTH - 1) ? '0 : wr_ptr + 1'b1;
                end
            end
            OP_REARM: begin
                rec_q = 1'b1;
            end
            OP_READ: begin
                r.entry_distance = log_flt[it.read_slot];
                r.entry_peak = log_pk[it.read_slot];
            end
            default: begin
            end
        endcase
        r.filtered_distance = flt0;
        r.peak_distance = peak_q;
        r.present = pres_q;
        r.recording = rec_q;
        r.write_position = wr_ptr;
    endtask

    task automatic send_item(input t_in_item it, input bit typed, input t_out_item want);
        int gap;
        t_out_item pred;
        gap = calm ? 0 : idle_len();
        if (gap != 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_item = it;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        detector_step(it, pred);
        expected_reports.push_back(typed ? want : pred);
        case (it.opcode)
            OP_SAMPLE: n_sample++;
            OP_REARM: n_rearm++;
            OP_READ: n_read++;
            default: n_unused++;
        endcase
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_in_valid = 1'b0;
        while (expected_reports.size() != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] value);
        logic [31:0] bits;
        bits = value;
        case (idx)
            REG_INVERSE_GAIN: begin
                bits = value & 32'h0003_FFFF;
                gain_r = bits[17:0];
            end
            REG_FEEDBACK_ONE: begin
                bits = value & 32'h0003_FFFF;
                fb1_r = bits[17:0];
            end
            REG_FEEDBACK_TWO: begin
                bits = value & 32'h0003_FFFF;
                fb2_r = bits[17:0];
            end
            REG_PEAK_LEAK: begin
                bits = value & 32'h0000_FFFF;
                leak_r = bits[15:0];
            end
            REG_RISE_FRACTION: begin
                bits = value & 32'h0001_FFFF;
                rise_r = bits[16:0];
            end
            REG_MARGIN: begin
                bits = value & 32'h00FF_FFFF;
                margin_r = bits[23:0];
            end
            default: begin
            end
        endcase
        paddr = {idx, 2'b00};
        pwdata = bits;
        pwrite = 1'b1;
        psel = 1'b1;
        penable = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        n_writes++;
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_reports.size() == 0) begin
                $error("result with no item pending: %h", o_out_item);
                err_count++;
            end else begin
                want = expected_reports.pop_front();
                check_field("filtered_distance", want.filtered_distance,
                            o_out_item.filtered_distance);
                check_field("peak_distance", want.peak_distance, o_out_item.peak_distance);
                check_field("present", 32'(want.present), 32'(o_out_item.present));
                check_field("recording", 32'(want.recording), 32'(o_out_item.recording));
                check_field("write_position", 32'(want.write_position),
                            32'(o_out_item.write_position));
                check_field("entry_distance", want.entry_distance, o_out_item.entry_distance);
                check_field("entry_peak", want.entry_peak, o_out_item.entry_peak);
                reports_checked++;
                if (o_out_item.present) begin
                    presence_hits++;
                end
            end
        end
    end

    initial begin
        int run_len;
        i_out_ready = 1'b1;
        forever begin
            i_out_ready = 1'b1;
            run_len = calm ? 1 : $urandom_range(1, 24);
            repeat (run_len) @(negedge i_clk);
            if (!calm) begin
                i_out_ready = 1'b0;
                repeat (1 + idle_len()) @(negedge i_clk);
            end
        end
    end

    initial begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
        end
        $display("tb_presence_detector_iir_peak: errors");
        $finish;
    end

    initial begin
        int phase;
        int target;
        int roll;
        int base;
        int drop;
        int hold;
        int jit;
        t_stim_row row;

        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_item = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        foreach (log_flt[k]) begin
            log_flt[k] = '0;
            log_pk[k] = '0;
        end

        directed.push_back(typed_row(OP_READ, 8'd0, 6'd0, 0, 0, 1'b0, 1'b1, 6'd0, 0, 0));
        directed.push_back(typed_row(OP_UNUSED, 8'd255, 6'd63, 0, 0, 1'b0, 1'b1, 6'd0, 0, 0));
        directed.push_back(typed_row(OP_REARM, 8'd0, 6'd0, 0, 0, 1'b0, 1'b1, 6'd0, 0, 0));
        directed.push_back(typed_row(OP_SAMPLE, 8'd0, 6'd0, 0, -99, 1'b0, 1'b1, 6'd1, 0, 0));
        directed.push_back(typed_row(OP_READ, 8'd0, 6'd0, 0, -99, 1'b0, 1'b1, 6'd1, 0, -99));
        directed.push_back(typed_row(OP_READ, 8'd0, 6'd63, 0, -99, 1'b0, 1'b1, 6'd1, 0, 0));
        directed.push_back(item_row(OP_SAMPLE, 8'd255, 6'd0));
        directed.push_back(item_row(OP_SAMPLE, 8'd255, 6'd0));
        directed.push_back(item_row(OP_SAMPLE, 8'd0, 6'd0));
        directed.push_back(item_row(OP_SAMPLE, 8'd0, 6'd0));
        directed.push_back(item_row(OP_READ, 8'd0, 6'd1));
        directed.push_back(item_row(OP_REARM, 8'd0, 6'd0));
        directed.push_back(item_row(OP_SAMPLE, 8'd128, 6'd0));
        directed.push_back(cfg_row(REG_INVERSE_GAIN, 32'h0003_FFFF));
        directed.push_back(cfg_row(REG_FEEDBACK_ONE, 32'h0002_0000));
        directed.push_back(cfg_row(REG_FEEDBACK_TWO, 32'h0002_0000));
        directed.push_back(cfg_row(REG_PEAK_LEAK, 32'h0000_FFFF));
        directed.push_back(cfg_row(REG_RISE_FRACTION, 32'h0001_0000));
        directed.push_back(cfg_row(REG_MARGIN, 32'h00FF_FFFF));
        directed.push_back(item_row(OP_SAMPLE, 8'd255, 6'd0));
        directed.push_back(item_row(OP_SAMPLE, 8'd255, 6'd0));
        directed.push_back(item_row(OP_SAMPLE, 8'd255, 6'd0));
        directed.push_back(item_row(OP_READ, 8'd0, 6'd3));
        directed.push_back(cfg_row(REG_RISE_FRACTION, 32'h0001_FFFF));
        directed.push_back(cfg_row(REG_FEEDBACK_ONE, 32'h0001_FFFF));
        directed.push_back(cfg_row(REG_FEEDBACK_TWO, 32'h0001_FFFF));
        directed.push_back(cfg_row(REG_INVERSE_GAIN, 32'h0000_0000));
        directed.push_back(cfg_row(REG_PEAK_LEAK, 32'h0000_0000));
        directed.push_back(cfg_row(REG_MARGIN, 32'h0000_0000));
        directed.push_back(item_row(OP_SAMPLE, 8'd85, 6'd0));
        directed.push_back(item_row(OP_SAMPLE, 8'd170, 6'd0));
        directed.push_back(item_row(OP_SAMPLE, 8'd0, 6'd0));
        directed.push_back(cfg_row(REG_INVERSE_GAIN, 32'd65536));
        directed.push_back(cfg_row(REG_FEEDBACK_ONE, 32'd0));
        directed.push_back(cfg_row(REG_FEEDBACK_TWO, 32'd0));
        directed.push_back(cfg_row(REG_PEAK_LEAK, 32'd109));
        directed.push_back(cfg_row(REG_RISE_FRACTION, 32'd6554));
        directed.push_back(item_row(OP_READ, 8'd0, 6'd63));
        directed.push_back(item_row(OP_UNUSED, 8'd170, 6'd42));
        directed.push_back(item_row(OP_REARM, 8'd0, 6'd0));
        directed.push_back(item_row(OP_SAMPLE, 8'd42, 6'd0));

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[k]) begin
            row = directed[k];
            if (row.is_cfg) begin
                settle();
                reg_write(row.reg_idx, row.value);
            end else begin
                send_item(row.item, row.typed, row.want);
            end
        end

        for (phase = 0; phase < N_PHASES; phase++) begin
            settle();
            calm = (phase % 4 == 3);
            if (phase % 3 == 2) begin
                reg_write(REG_INVERSE_GAIN, $urandom());
                reg_write(REG_FEEDBACK_ONE, $urandom());
                reg_write(REG_FEEDBACK_TWO, $urandom());
                reg_write(REG_PEAK_LEAK, $urandom());
                reg_write(REG_RISE_FRACTION, $urandom());
                reg_write(REG_MARGIN, $urandom());
            end else begin
                reg_write(REG_INVERSE_GAIN, $urandom_range(32768, 98304));
                reg_write(REG_FEEDBACK_ONE, -$urandom_range(32768, 98304));
                reg_write(REG_FEEDBACK_TWO, $urandom_range(0, 26000));
                reg_write(REG_PEAK_LEAK, $urandom_range(0, 3000));
                reg_write(REG_RISE_FRACTION, $urandom_range(1000, 65536));
                reg_write(REG_MARGIN, $urandom_range(0, 40 << 16));
            end
            target = n_sample + n_read + n_rearm + PHASE_ITEMS;
            while (n_sample + n_read + n_rearm < target) begin
                roll = $urandom_range(0, 99);
                if (roll < 70) begin
                    base = $urandom_range(120, 250);
                    drop = $urandom_range(10, 110);
                    hold = $urandom_range(4, 30);
                    repeat (hold) begin
                        jit = $urandom_range(0, 6);
                        send_item(mk_item(OP_SAMPLE, 8'(base + jit - 3), '0), 1'b0, '0);
                    end
                    hold = $urandom_range(2, 16);
                    repeat (hold) begin
                        jit = $urandom_range(0, 6);
                        send_item(mk_item(OP_SAMPLE, 8'(base - drop + jit - 3), '0),
                                  1'b0, '0);
                    end
                    repeat ($urandom_range(0, 3)) begin
                        send_item(mk_item(OP_READ, 8'($urandom()),
                                          6'($urandom_range(0, 63))), 1'b0, '0);
                    end
                    if ($urandom_range(0, 9) < 6) begin
                        send_item(mk_item(OP_REARM, 8'($urandom()), 6'($urandom())),
                                  1'b0, '0);
                    end
                end else if (roll < 85) begin
                    repeat ($urandom_range(1, 4)) begin
                        send_item(mk_item(OP_READ, 8'($urandom()),
                                          6'($urandom_range(0, 63))), 1'b0, '0);
                    end
                end else begin
                    repeat ($urandom_range(1, 5)) begin
                        send_item(mk_item(2'($urandom_range(0, 3)), 8'($urandom()),
                                          6'($urandom())), 1'b0, '0);
                    end
                end
            end
        end

        i_in_valid = 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
        repeat (24) @(posedge i_clk);
        $display("covered %0d samples, %0d reads, %0d re-arms, %0d unused-opcode items",
                 n_sample, n_read, n_rearm, n_unused);
        $display("%0d reg writes; compared %0d results, %0d of them with presence flagged",
                 n_writes, reports_checked, presence_hits);
        if (err_count == 0) begin
            $display("tb_presence_detector_iir_peak: clean");
        end else begin
            $display("tb_presence_detector_iir_peak: errors");
        end
        $finish;
    end

endmodule

/* presence_detector_iir_peak.f */
sv/pdip_pkg.sv
sv/pdip_cfg.sv
sv/pdip_ctrl.sv
sv/pdip_dp.sv
sv/presence_detector_iir_peak.sv
tb/tb_presence_detector_iir_peak.sv
